// ===== rtl/core/skpc_pkg.sv =====
`default_nettype none
package skpc_pkg;

  localparam int WINDOW_SECONDS_DEF = 60;

  localparam int TIME_W      = 32;
  localparam int CODE_W      = 8;
  localparam int BUCKET_W    = 8;
  localparam int TOTAL_W     = 14;
  localparam int RELEASE_BIT = 7;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX = 8'd255;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 14'd16383;

  localparam logic MODE_SCANCODE = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EVAL     = 6'b000010,
    ST_STEP     = 6'b000100,
    ST_PRESS_RD = 6'b001000,
    ST_PRESS_WR = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;      // capture the input word
    logic eval;      // compare time, set up sweep or full clear
    logic step;      // retire one bucket of the sweep
    logic press_wr;  // count the press into the current bucket
    logic out_load;  // move the total to the output register
  } cmd_t;

  typedef struct packed {
    logic adv;       // time moved forward
    logic big;       // a whole window or more has passed
    logic step_last; // final bucket of the sweep
    logic out_busy;  // output register still holds an untaken word
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/skpc_ctrl.sv =====
`default_nettype none
module skpc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  skpc_pkg::sts_t    sts,
  output skpc_pkg::cmd_t    cmd
);

  skpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == skpc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      skpc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = skpc_pkg::ST_EVAL;
        end
      end
      skpc_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.adv || sts.big) begin
          state_nxt = skpc_pkg::ST_PRESS_RD;
        end else begin
          state_nxt = skpc_pkg::ST_STEP;
        end
      end
      skpc_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_nxt = skpc_pkg::ST_PRESS_RD;
        end
      end
      skpc_pkg::ST_PRESS_RD: begin
        state_nxt = skpc_pkg::ST_PRESS_WR;
      end
      skpc_pkg::ST_PRESS_WR: begin
        cmd.press_wr = 1'b1;
        state_nxt    = skpc_pkg::ST_DONE;
      end
      skpc_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = skpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/skpc_dp.sv =====
`default_nettype none
module skpc_dp #(
  parameter int WINDOW_SECONDS = skpc_pkg::WINDOW_SECONDS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_mode,
  input  wire [skpc_pkg::CODE_W-1:0]       in_code,
  input  wire [skpc_pkg::TIME_W-1:0]       in_now,
  input  skpc_pkg::cmd_t                   cmd,
  output skpc_pkg::sts_t                   sts,
  input  wire                              out_tready,
  output logic                             out_tvalid,
  output logic [skpc_pkg::TOTAL_W-1:0]     out_total
);

  localparam int SLOT_W = $clog2(WINDOW_SECONDS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SECONDS - 1);
  localparam logic [skpc_pkg::TIME_W-1:0] WIN_TIME = skpc_pkg::TIME_W'(WINDOW_SECONDS);

  logic                            mode_r;
  logic [skpc_pkg::CODE_W-1:0]     code_r;
  logic [skpc_pkg::TIME_W-1:0]     now_r;
  logic [skpc_pkg::TIME_W-1:0]     last_r, last_nxt;
  logic [SLOT_W-1:0]               slot_r, slot_nxt;
  logic [SLOT_W-1:0]               cnt_r, cnt_nxt;
  logic [skpc_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic                            pend_r;
  logic [WINDOW_SECONDS-1:0]       vld_r, vld_nxt;
  logic [skpc_pkg::BUCKET_W-1:0]   rd_data_r;
  logic                            rd_vld_r;
  logic                            out_vld_r;
  logic [skpc_pkg::TOTAL_W-1:0]    out_data_r;

  logic [skpc_pkg::BUCKET_W-1:0]   mem [WINDOW_SECONDS];

  logic [skpc_pkg::TIME_W-1:0]     gap;
  logic [SLOT_W-1:0]               slot_inc;
  logic [SLOT_W-1:0]               rd_addr;
  logic [skpc_pkg::BUCKET_W-1:0]   rd_val;
  logic                            press;
  logic                            inc_ok;

  assign gap      = now_r - last_r;
  assign slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign rd_addr  = cmd.step ? slot_inc : slot_r;
  assign rd_val   = rd_vld_r ? rd_data_r : '0;
  assign press    = (mode_r == skpc_pkg::MODE_SCANCODE) && !code_r[skpc_pkg::RELEASE_BIT];
  assign inc_ok   = press && (rd_val != skpc_pkg::BUCKET_MAX)
                    && (total_r != skpc_pkg::TOTAL_MAX);

  assign sts.adv       = now_r > last_r;
  assign sts.big       = gap >= WIN_TIME;
  assign sts.step_last = (cnt_r == SLOT_W'(1));
  assign sts.out_busy  = out_vld_r && !out_tready;

  always_comb begin
    last_nxt  = last_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    vld_nxt   = vld_r;

    // retire the bucket read on the previous sweep cycle
    if (pend_r) begin
      total_nxt = (total_r >= skpc_pkg::TOTAL_W'(rd_val))
                  ? total_r - skpc_pkg::TOTAL_W'(rd_val) : '0;
    end

    if (cmd.eval && sts.adv) begin
      last_nxt = now_r;
      // empty the whole ring and hold the slot: the ring is only ever walked
      // by distance from last_r, so its starting position is free
      if (sts.big) begin
        vld_nxt   = '0;
        total_nxt = '0;
      end else begin
        cnt_nxt = gap[SLOT_W-1:0];
      end
    end

    if (cmd.step) begin
      slot_nxt          = slot_inc;
      vld_nxt[slot_inc] = 1'b0;
      cnt_nxt           = cnt_r - 1'b1;
    end

    if (cmd.press_wr && inc_ok) begin
      vld_nxt[slot_r] = 1'b1;
      total_nxt       = total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      slot_r    <= '0;
      total_r   <= '0;
      vld_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      last_r  <= last_nxt;
      slot_r  <= slot_nxt;
      total_r <= total_nxt;
      vld_r   <= vld_nxt;
      pend_r  <= cmd.step;
      cnt_r   <= cnt_nxt;
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      code_r <= in_code;
      now_r  <= in_now;
    end
    if (cmd.out_load) begin
      out_data_r <= total_r;
    end
  end

  // bucket store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.press_wr && inc_ok) begin
      mem[slot_r] <= rd_val + 1'b1;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign out_tvalid = out_vld_r;
  assign out_total  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/sliding_minute_keypress_counter_core.sv =====
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | in_tdata, in_tuser
// out_    | output    | out_tvalid/tready  | out_tdata
//
// A word passes ST_IDLE, ST_EVAL, one ST_STEP per second when time moves forward by
// gap below the window (none otherwise), then ST_PRESS_RD, ST_PRESS_WR and ST_DONE.
// The sweep clears one bucket a cycle through the single read port; a whole-window
// jump drops every bucket at once via valid bits.
// Reset (rst_n low, synchronous) empties every bucket at once via valid bits.
// A held result stalls the controller in ST_DONE; no new word is taken meanwhile.
module sliding_minute_keypress_counter_core #(
  parameter int WINDOW_SECONDS = skpc_pkg::WINDOW_SECONDS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [7:0] scancode, [39:8] now_seconds
  input  wire         in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [13:0] presses_last_minute, [15:14] zero
);

  skpc_pkg::cmd_t cmd;
  skpc_pkg::sts_t sts;
  logic [skpc_pkg::TOTAL_W-1:0] total;

  skpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skpc_dp #(
    .WINDOW_SECONDS (WINDOW_SECONDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_code    (in_tdata[7:0]),
    .in_now     (in_tdata[39:8]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_total  (total)
  );

  assign out_tdata = {2'b00, total};

endmodule
`default_nettype wire

// ===== tb/sliding_minute_keypress_counter_core_tb.sv =====
`timescale 1ns / 1ps
module sliding_minute_keypress_counter_core_tb;

  localparam int          WIN         = skpc_pkg::WINDOW_SECONDS_DEF;
  localparam logic        MODE_TICK   = ~skpc_pkg::MODE_SCANCODE;
  localparam int          RAND_WORDS  = 220;
  localparam int          STALL_PCT   = 22;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [7:0] scancode, [39:8] now_seconds
  logic        in_tuser   = 1'b0; // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [13:0] presses_last_minute, [15:14] zero

  logic        idle_on    = 1'b1;
  int unsigned cycle_cnt  = 0;
  int          fails      = 0;

  // shadow of the counter state
  logic [skpc_pkg::BUCKET_W-1:0] sec_count [WIN];
  logic [skpc_pkg::TIME_W-1:0]   seen_second;
  logic [skpc_pkg::TOTAL_W-1:0]  press_total;
  logic [skpc_pkg::TOTAL_W-1:0]  pending_totals [$];
  logic [skpc_pkg::TOTAL_W-1:0]  want_total;

  sliding_minute_keypress_counter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL sliding_minute_keypress_counter_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_totals.size() == 0) begin
        $error("presses_last_minute: expected none, actual %0d", out_tdata[13:0]);
        fails++;
      end else begin
        want_total = pending_totals.pop_front();
        if (out_tdata[13:0] !== want_total) begin
          $error("presses_last_minute: expected %0d, actual %0d",
                 want_total, out_tdata[13:0]);
          fails++;
        end
        if (out_tdata[15:14] !== 2'b00) begin
          $error("out_tdata padding: expected 0, actual %0d", out_tdata[15:14]);
          fails++;
        end
      end
    end
  end

  // Sweep the expired seconds, then count the press into the current bucket.
  task automatic tally_word(input logic mode, input logic [skpc_pkg::CODE_W-1:0] code,
                            input logic [skpc_pkg::TIME_W-1:0] t);
    logic [skpc_pkg::TIME_W-1:0] gap;
    int                          idx;
    begin
      if (t > seen_second) begin
        gap = t - seen_second;
        if (gap >= skpc_pkg::TIME_W'(WIN)) begin
          foreach (sec_count[i]) sec_count[i] = '0;
          press_total = '0;
        end else begin
          idx = int'(seen_second % skpc_pkg::TIME_W'(WIN));
          for (int k = 0; k < int'(gap); k++) begin
            idx = (idx == WIN - 1) ? 0 : idx + 1;
            if (press_total >= sec_count[idx]) press_total = press_total - sec_count[idx];
            else press_total = '0;
            sec_count[idx] = '0;
          end
        end
        seen_second = t;
      end
      if (mode == skpc_pkg::MODE_SCANCODE && !code[skpc_pkg::RELEASE_BIT]) begin
        idx = int'(seen_second % skpc_pkg::TIME_W'(WIN));
        if (sec_count[idx] < skpc_pkg::BUCKET_MAX
            && press_total < skpc_pkg::TOTAL_MAX) begin
          sec_count[idx] = sec_count[idx] + 1'b1;
          press_total    = press_total + 1'b1;
        end
      end
      pending_totals.push_back(press_total);
    end
  endtask

  task automatic push_word(input logic mode, input logic [skpc_pkg::CODE_W-1:0] code,
                           input logic [skpc_pkg::TIME_W-1:0] t);
    int gap_cycles;
    begin
      gap_cycles = 0;
      if (idle_on) while ($urandom_range(0, 99) < STALL_PCT) gap_cycles++;
      if (gap_cycles > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_cycles) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {t, code};
      in_tuser  <= mode;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      tally_word(mode, code, t);
    end
  endtask

  task automatic test_reset_state;
    push_word(MODE_TICK, 8'h00, 32'd0);
  endtask

  task automatic test_codes_and_gaps;
    push_word(skpc_pkg::MODE_SCANCODE, 8'h00, 32'd0);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h7F, 32'd0);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h80, 32'd0);   // release codes only advance time
    push_word(skpc_pkg::MODE_SCANCODE, 8'hFF, 32'd0);
    push_word(MODE_TICK,               8'h00, 32'd0);   // tick ignores the scancode
    push_word(skpc_pkg::MODE_SCANCODE, 8'h55, 32'd1);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h2A, 32'd2);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h11, 32'd60);  // two short of a whole window
    push_word(MODE_TICK,               8'hFF, 32'd61);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h3C, 32'd5);   // time going backwards
    push_word(MODE_TICK,               8'h00, 32'd120); // gap of 59 keeps one bucket
    push_word(skpc_pkg::MODE_SCANCODE, 8'h01, 32'd180); // exactly a window
    push_word(skpc_pkg::MODE_SCANCODE, 8'h02, 32'd241); // just over a window
    push_word(MODE_TICK,               8'h00, 32'd241 + 32'h7FFF_0000);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h40, 32'hAAAA_AAAA);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h20, 32'h5555_5555);
    push_word(MODE_TICK,               8'hFF, 32'hAAAA_AAAA + 32'd59);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h0F, 32'hAAAA_AAAA + 32'd59);
  endtask

  // Fill one bucket past its ceiling with no idling on either side.
  task automatic test_full_bucket;
    logic [skpc_pkg::TIME_W-1:0] t;
    begin
      idle_on = 1'b0;
      t = seen_second + 1;
      for (int i = 0; i < 258; i++) push_word(skpc_pkg::MODE_SCANCODE, 8'h1C, t);
      push_word(MODE_TICK, 8'h00, t + 1);
      push_word(MODE_TICK, 8'h00, t + 60);
      idle_on = 1'b1;
    end
  endtask

  task automatic test_random_traffic;
    int                          pick;
    int unsigned                 back;
    logic                        mode;
    logic [skpc_pkg::CODE_W-1:0] code;
    logic [skpc_pkg::TIME_W-1:0] t;
    begin
      for (int i = 0; i < RAND_WORDS; i++) begin
        pick = $urandom_range(0, 99);
        t    = seen_second;
        if (pick < 80) begin
          if (seen_second <= 32'hFFFF_FF00) begin
            if (pick < 60)      t = seen_second + $urandom_range(0, 1);
            else if (pick < 72) t = seen_second + $urandom_range(2, 8);
            else                t = seen_second + $urandom_range(50, 70);
          end
        end else if (pick < 88) begin
          back = $urandom_range(1, 90);
          t = (back > seen_second) ? '0 : seen_second - back;
        end else if (pick < 91) begin
          t = $urandom;
        end
        mode = ($urandom_range(0, 99) < 80) ? skpc_pkg::MODE_SCANCODE : MODE_TICK;
        code = skpc_pkg::CODE_W'($urandom);
        if (mode == skpc_pkg::MODE_SCANCODE) begin
          code[skpc_pkg::RELEASE_BIT] = ($urandom_range(0, 99) >= 75);
        end
        push_word(mode, code, t);
      end
    end
  endtask

  task automatic test_time_ceiling;
    push_word(skpc_pkg::MODE_SCANCODE, 8'h33, 32'hFFFF_FFFF);
    push_word(skpc_pkg::MODE_SCANCODE, 8'h34, 32'hFFFF_FFFE);
    push_word(MODE_TICK,               8'h00, 32'd0);
  endtask

  initial begin
    foreach (sec_count[i]) sec_count[i] = '0;
    seen_second = '0;
    press_total = '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_codes_and_gaps();
    test_full_bucket();
    test_random_traffic();
    test_time_ceiling();
    in_tvalid <= 1'b0;

    while (pending_totals.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("PASS sliding_minute_keypress_counter_core");
    end else begin
      $display("FAIL sliding_minute_keypress_counter_core");
    end
    $finish;
  end

endmodule
